// ===== src/rtt_pkg.sv =====
// package: controller states, status codes and hash constants of the rtt slot table
package rtt_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_H,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_WB
  } state_e;

  typedef enum logic [2:0] {
    STAT_STORED  = 3'd0,
    STAT_REFRESH = 3'd1,
    STAT_BUSY    = 3'd2,
    STAT_RTT     = 3'd3,
    STAT_NOMATCH = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_FLOW_SEED = 2'd0,
    REG_SEQ_SEED  = 2'd1,
    REG_TWO_LAYER = 2'd2,
    REG_TIMEOUT   = 2'd3
  } reg_idx_e;

  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_N  = 32'he6546b64;
  localparam logic [31:0] MM_F1 = 32'h85ebca6b;
  localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

  localparam logic [31:0] KEY_LEN  = 32'd16;
  localparam logic [31:0] FLOW_LEN = 32'd12;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned ENTRY_W = 1 + KEY_W + TIME_W;

  localparam logic [47:0] TIMEOUT_RST = 48'd30000000;

endpackage

// ===== src/rtt_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module rtt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rtt_sample_table.sv =====
// top level: hashed slot table that measures round-trip times from probe and ack words
// steps per accepted word: 4 words x 3 hash steps, 3 finalize steps with the table read
//   issued in the last, then 1 decide and write back step before the result is valid
// one word at a time: the shared murmur3 step sequencer takes the next word only from idle,
//   after write back, and stays in write back while the last result still waits for out_ready_i
// reset: clears control, sets config to its reset values, then sweeps the table
//   one entry a cycle, clearing all SLOTS entries, before the first word is taken
// SLOTS must be a power of two; the slot number is the low bits of the index hash
module rtt_sample_table
  import rtt_pkg::*;
#(
  parameter int unsigned SLOTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [31:0] seq_number_i,
  input  logic [47:0] now_ns_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [47:0] rtt_ns_o,
  output logic [9:0]  slot_index_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned EXT_W = IW + 10;

  // config registers
  logic [31:0] flow_seed_q, seq_seed_q;
  logic        two_layer_q;
  logic [47:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_seed_q <= '0;
      seq_seed_q  <= '0;
      two_layer_q <= 1'b1;
      timeout_q   <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_FLOW_SEED: flow_seed_q <= cfg_data_i[31:0];
        REG_SEQ_SEED:  seq_seed_q  <= cfg_data_i[31:0];
        REG_TWO_LAYER: two_layer_q <= cfg_data_i[0];
        REG_TIMEOUT:   timeout_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // controller state
  state_e        state_q, state_d;
  logic [1:0]    widx_q;     // hash word counter
  logic [IW-1:0] clr_q;      // clearing sweep address
  logic          out_valid_q;
  logic          advance;    // result register free to load

  // captured word and datapath registers
  logic        op_q;
  logic [31:0] w_q [4];
  logic [47:0] now_q;
  logic [31:0] m_q, k_q, hk_q, hf_q, key_q;
  logic [IW-1:0] slot_q;
  logic [2:0]  status_q;
  logic [47:0] rtt_q;
  logic [9:0]  slot_idx_q;

  // table access
  logic               ram_we, ram_re;
  logic [IW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  assign advance = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_K1;
      ST_K1:    state_d = ST_K2;
      ST_K2:    state_d = ST_H;
      ST_H:     state_d = (widx_q == 2'd3) ? ST_F1 : ST_K1;
      ST_F1:    state_d = ST_F2;
      ST_F2:    state_d = ST_F3;
      ST_F3:    state_d = ST_WB;
      ST_WB:    if (advance) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // final hash of the finalize stage, slot pick
  logic [31:0]   key_fin, flow_fin, idx_hash;
  logic [IW-1:0] slot_fin;

  assign key_fin  = hk_q ^ {16'b0, hk_q[31:16]};
  assign flow_fin = hf_q ^ {16'b0, hf_q[31:16]};
  assign idx_hash = two_layer_q ? (flow_fin ^ {28'b0, key_fin[3:0]}) : key_fin;
  assign slot_fin = idx_hash[IW-1:0];

  // slot decision on the read entry
  logic        ent_valid;
  logic [31:0] ent_key;
  logic [47:0] ent_time, age;
  logic        hit, expired;
  logic [2:0]  status_d;
  logic [47:0] rtt_d;
  logic        upd_we;
  logic [ENTRY_W-1:0] upd_data;

  assign {ent_valid, ent_key, ent_time} = ram_rdata;
  assign age     = (now_q >= ent_time) ? (now_q - ent_time) : 48'd0;
  assign hit     = ent_valid && (ent_key == key_q);
  assign expired = age > timeout_q;

  always_comb begin
    status_d = STAT_NOMATCH;
    rtt_d    = '0;
    upd_we   = 1'b0;
    upd_data = {1'b1, key_q, now_q};
    if (!op_q) begin
      priority if (hit) begin
        status_d = STAT_REFRESH;
        upd_we   = 1'b1;
      end else if (!ent_valid || expired) begin
        status_d = STAT_STORED;
        upd_we   = 1'b1;
      end else begin
        status_d = STAT_BUSY;
      end
    end else begin
      if (hit) begin
        status_d = STAT_RTT;
        rtt_d    = age;
        upd_we   = 1'b1;
        upd_data = '0;
      end
    end
  end

  // outputs of the controller
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    ram_re     = (state_q == ST_F3);
    ram_we     = 1'b0;
    ram_waddr  = slot_q;
    ram_wdata  = upd_data;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_WB:    ram_we = advance && upd_we;
      default: ;
    endcase
  end

  rtt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (slot_fin),
    .rdata_o (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == ST_IDLE) widx_q <= '0;
      else if (state_q == ST_H) widx_q <= widx_q + 1'b1;
      out_valid_q <= (out_valid_q && !out_ready_i) || (state_q == ST_WB && advance);
    end
  end

  // hash datapath, at most one multiply deep per step
  logic [31:0] hk_x, hf_x, hk_r, hf_r, hk_t, hf_t;
  logic [EXT_W-1:0] slot_ext;

  assign hk_x = hk_q ^ k_q;
  assign hf_x = hf_q ^ k_q;
  assign hk_r = {hk_x[18:0], hk_x[31:19]};
  assign hf_r = {hf_x[18:0], hf_x[31:19]};
  // first finalize step: mix in length and high half
  assign hk_t = (hk_q ^ KEY_LEN) ^ {16'b0, hk_q[31:16] ^ KEY_LEN[31:16]};
  assign hf_t = (hf_q ^ FLOW_LEN) ^ {16'b0, hf_q[31:16] ^ FLOW_LEN[31:16]};
  assign slot_ext = {10'b0, slot_q};

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_q  <= opcode_i;
          w_q[0] <= src_addr_i;
          w_q[1] <= dst_addr_i;
          w_q[2] <= {dst_port_i, src_port_i};
          w_q[3] <= seq_number_i;
          now_q <= now_ns_i;
          hk_q  <= seq_seed_q;
          hf_q  <= flow_seed_q;
        end
      end
      ST_K1: m_q <= w_q[widx_q] * MM_C1;
      ST_K2: k_q <= {m_q[16:0], m_q[31:17]} * MM_C2;
      ST_H: begin
        hk_q <= (hk_r << 2) + hk_r + MM_N;
        if (widx_q != 2'd3) hf_q <= (hf_r << 2) + hf_r + MM_N;
      end
      ST_F1: begin
        hk_q <= hk_t * MM_F1;
        hf_q <= hf_t * MM_F1;
      end
      ST_F2: begin
        hk_q <= (hk_q ^ {13'b0, hk_q[31:13]}) * MM_F2;
        hf_q <= (hf_q ^ {13'b0, hf_q[31:13]}) * MM_F2;
      end
      ST_F3: begin
        key_q  <= key_fin;
        slot_q <= slot_fin;
      end
      ST_WB: begin
        if (advance) begin
          status_q   <= status_d;
          rtt_q      <= rtt_d;
          slot_idx_q <= slot_ext[9:0];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign rtt_ns_o     = rtt_q;
  assign slot_index_o = slot_idx_q;

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !in_ready_o)
    else $error("word accepted during table clear");

  a_rtt_only_measured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_RTT |-> rtt_ns_o == 48'd0)
    else $error("rtt reported without a measurement");

  a_write_when_allowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == ST_CLEAR || (state_q == ST_WB && advance))
    else $error("table write outside clear or write back");

endmodule

// ===== tb/sv/tb_top.sv =====
// rtt_sample_table testbench: directed and random probe and ack words checked against a murmur3 slot predictor
`timescale 1ns / 100ps

module tb_top;
  import rtt_pkg::*;

  localparam int unsigned NSLOT = 1024;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam logic OP_PROBE = 1'b0;
  localparam logic OP_ACK   = 1'b1;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq;
  } flow_t;

  typedef struct packed {
    logic        op;
    flow_t       fl;
    logic [47:0] now;
  } rtt_word_t;

  typedef struct packed {
    status_e     st;
    logic [47:0] rtt;
    logic [9:0]  slot;
  } rtt_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // config port, driven only from the sequencing block
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  // input channel
  logic      in_valid = 1'b0;
  logic      in_ready;
  rtt_word_t cur_word = '0;

  // output channel
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [47:0] rtt_ns;
  logic [9:0]  slot_index;

  rtt_sample_table #(.SLOTS(NSLOT)) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .opcode_i     (cur_word.op),
    .src_addr_i   (cur_word.fl.src),
    .dst_addr_i   (cur_word.fl.dst),
    .src_port_i   (cur_word.fl.sport),
    .dst_port_i   (cur_word.fl.dport),
    .seq_number_i (cur_word.fl.seq),
    .now_ns_i     (cur_word.now),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .rtt_ns_o     (rtt_ns),
    .slot_index_o (slot_index)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the config registers and the slot table
  logic [31:0] flow_seed = '0;
  logic [31:0] seq_seed = '0;
  logic        two_layer = 1'b1;
  logic [47:0] timeout_ns = TIMEOUT_RST;
  bit          slot_used [NSLOT];
  logic [31:0] slot_key [NSLOT];
  logic [47:0] slot_stamp [NSLOT];

  rtt_word_t   word_q [$];   // words waiting to be offered
  rtt_result_t result_q [$]; // results predicted, not yet seen
  int unsigned errors = 0;

  // idle percentages per side, set per phase
  int unsigned snd_idle_pct = 9;
  int unsigned rcv_idle_pct = 79;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;

  // murmur3-32 over n little-endian words
  function automatic logic [31:0] murmur3(input flow_t f, input int n, input logic [31:0] seed);
    logic [31:0] w [4];
    logic [31:0] h;
    logic [31:0] k;
    w[0] = f.src;
    w[1] = f.dst;
    w[2] = {f.dport, f.sport};
    w[3] = f.seq;
    h = seed;
    for (int i = 0; i < n; i++) begin
      k = w[i] * MM_C1;
      k = {k[16:0], k[31:17]};
      k = k * MM_C2;
      h = h ^ k;
      h = {h[18:0], h[31:19]};
      h = h * 32'd5 + MM_N;
    end
    h = h ^ (n * 4);
    h = h ^ (h >> 16);
    h = h * MM_F1;
    h = h ^ (h >> 13);
    h = h * MM_F2;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // work out the result of one accepted word and update the table copy
  function automatic void predict_slot_access(input rtt_word_t w);
    logic [31:0] key;
    logic [31:0] idx;
    logic [47:0] age;
    rtt_result_t r;
    key = murmur3(w.fl, 4, seq_seed);
    if (two_layer)
      idx = (murmur3(w.fl, 3, flow_seed) ^ (key & 32'd15)) % NSLOT;
    else
      idx = key % NSLOT;
    // clock behind the stored time counts as zero age
    age = (w.now >= slot_stamp[idx]) ? w.now - slot_stamp[idx] : '0;
    r.rtt = '0;
    r.slot = idx[9:0];
    if (w.op == OP_PROBE) begin
      if (slot_used[idx] && slot_key[idx] == key) begin
        slot_stamp[idx] = w.now;
        r.st = STAT_REFRESH;
      end else if (!slot_used[idx] || age > timeout_ns) begin
        slot_used[idx] = 1'b1;
        slot_key[idx] = key;
        slot_stamp[idx] = w.now;
        r.st = STAT_STORED;
      end else begin
        r.st = STAT_BUSY;
      end
    end else begin
      if (slot_used[idx] && slot_key[idx] == key) begin
        r.rtt = age;
        slot_used[idx] = 1'b0;
        slot_key[idx] = '0;
        slot_stamp[idx] = '0;
        r.st = STAT_RTT;
      end else begin
        r.st = STAT_NOMATCH;
      end
    end
    result_q = {result_q, r};
  endfunction

  // driver: offers queued words, predicts each one on acceptance
  always @(posedge clk or negedge rst_n) begin
    logic take;
    logic nxt_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && in_ready;
      if (take)
        predict_slot_access(cur_word);
      nxt_valid = in_valid && !take;
      // a new word only once the old one is gone; valid never drops early
      if (!nxt_valid && word_q.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        cur_word <= word_q.pop_front();
        nxt_valid = 1'b1;
      end
      in_valid <= nxt_valid;
    end
  end

  // monitor: compares each result word with the oldest prediction
  always @(posedge clk or negedge rst_n) begin
    rtt_result_t e;
    int unsigned hold_left;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result word with nothing expected: status %0d slot %0d", status, slot_index);
          errors++;
        end else begin
          e = result_q.pop_front();
          if (status !== e.st) begin
            $error("status: expected %0d, got %0d", e.st, status);
            errors++;
          end
          if (rtt_ns !== e.rtt) begin
            $error("rtt_ns: expected %0d, got %0d", e.rtt, rtt_ns);
            errors++;
          end
          if (slot_index !== e.slot) begin
            $error("slot_index: expected %0d, got %0d", e.slot, slot_index);
            errors++;
          end
        end
      end
      // long receiver hold-off so the block backs up into its input
      if (hold_go && !hold_done && hold_left == 0)
        hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0)
          hold_done = 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // cycle limit
  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic cfg_write(input reg_idx_e idx, input logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FLOW_SEED: flow_seed = val[31:0];
      REG_SEQ_SEED:  seq_seed = val[31:0];
      REG_TWO_LAYER: two_layer = val[0];
      REG_TIMEOUT:   timeout_ns = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] fs, input logic [31:0] ss,
                           input logic tl, input logic [47:0] tmo);
    cfg_write(REG_FLOW_SEED, {16'h0, fs});
    cfg_write(REG_SEQ_SEED, {16'h0, ss});
    cfg_write(REG_TWO_LAYER, {47'h0, tl});
    cfg_write(REG_TIMEOUT, tmo);
  endtask

  // wait until every word went in and every result came out, then cover latency
  // checked at the falling edge so the driver and monitor updates have settled
  task automatic drain();
    while (word_q.size() > 0 || in_valid || result_q.size() > 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic void queue_word(input logic op, input flow_t f, input logic [47:0] t);
    rtt_word_t w;
    w.op = op;
    w.fl = f;
    w.now = t;
    word_q = {word_q, w};
  endfunction

  logic [47:0] clock_ns = 48'd1000;

  // random traffic: a few tuples with many sequences so slots collide and acks match
  task automatic random_traffic(input int n, input int unsigned step_max);
    flow_t tuples [6];
    flow_t inflight [$];
    flow_t f;
    logic [47:0] t;
    int unsigned r;
    int unsigned pick;
    for (int i = 0; i < 6; i++)
      tuples[i] = {$urandom(), $urandom(), 16'($urandom), 16'($urandom), 32'h0};
    for (int i = 0; i < n; i++) begin
      clock_ns = clock_ns + $urandom_range(1, step_max);
      t = clock_ns;
      if ($urandom_range(0, 99) < 5)
        t = clock_ns - $urandom_range(0, 2 * step_max); // clock behind stored time
      r = $urandom_range(0, 99);
      if (r < 40 || inflight.size() == 0) begin
        f = tuples[$urandom_range(0, 5)];
        f.seq = $urandom();
        inflight = {inflight, f};
        if (inflight.size() > 40)
          void'(inflight.pop_front());
        queue_word(OP_PROBE, f, t);
      end else if (r < 55) begin
        queue_word(OP_PROBE, inflight[$urandom_range(0, inflight.size() - 1)], t);
      end else if (r < 88) begin
        pick = $urandom_range(0, inflight.size() - 1);
        queue_word(OP_ACK, inflight[pick], t);
        inflight.delete(pick);
      end else if (r < 94) begin
        f = tuples[$urandom_range(0, 5)];
        f.seq = $urandom();
        queue_word(OP_ACK, f, t);
      end else begin
        // noise: fully random word
        f = {$urandom(), $urandom(), 16'($urandom), 16'($urandom), $urandom()};
        queue_word(1'($urandom), f, {16'($urandom), $urandom()});
      end
    end
  endtask

  initial begin
    flow_t f;
    for (int i = 0; i < NSLOT; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_stamp[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at reset config: field extremes, refresh, rtt, no match, clock behind
    f = '0;
    queue_word(OP_PROBE, f, 48'd0);
    queue_word(OP_PROBE, f, 48'd500);
    queue_word(OP_ACK, f, 48'd1700);
    queue_word(OP_ACK, f, 48'd1800);
    f = '1;
    queue_word(OP_PROBE, f, '1);
    queue_word(OP_ACK, f, '1);
    f = {32'h12345678, 32'h9abcdef0, 16'h0050, 16'hc000, 32'h00001000};
    queue_word(OP_PROBE, f, 48'd90000);
    queue_word(OP_ACK, f, 48'd80000);
    queue_word(OP_PROBE, f, 48'd100000);
    f.seq = 32'h00002000;
    queue_word(OP_PROBE, f, 48'd100010);
    queue_word(OP_ACK, f, 48'd250000);
    drain();

    // phase 1: reset config, sender idles little, receiver a lot
    random_traffic(320, 4000);
    drain();

    // phase 2: zero timeout, sequence hash only
    configure($urandom(), $urandom(), 1'b0, 48'd0);
    random_traffic(320, 3000);
    drain();

    // phase 3: maximum seeds and timeout, roles of idling swapped
    snd_idle_pct = 79;
    rcv_idle_pct = 9;
    configure('1, '1, 1'b1, 48'hffff_ffff_ffff);
    random_traffic(320, 5000);
    drain();

    // phase 4: short timeout, time near the top of the 48-bit range
    configure('0, '0, 1'b1, 48'd4000);
    clock_ns = 48'hffff_0000_0000 | 48'($urandom);
    random_traffic(320, 3000);
    drain();

    // phase 5: no idling, long receiver hold-off, sender pause midway
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    configure($urandom(), $urandom(), 1'b1, 48'd20000);
    clock_ns = {16'($urandom), $urandom()};
    hold_go = 1'b1;
    random_traffic(180, 6000);
    drain();
    random_traffic(180, 6000);
    drain();
    repeat (40) @(posedge clk);

    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rtt_pkg.sv
src/rtt_ram.sv
src/rtt_sample_table.sv
tb/sv/tb_top.sv
